// ----- hw/rtl/pfd_pkg.sv -----
package pfd_pkg;

	localparam logic [7:0] FRAME_FLAG = 8'hF7;

	localparam int HDR_IDX_W = 4;
	localparam int TDATA_W   = 80;
	localparam int TUSER_W   = 2;

	// Header byte positions, little-endian fields in order.
	localparam logic [HDR_IDX_W-1:0] HDR_DEST_LO   = 4'd0;
	localparam logic [HDR_IDX_W-1:0] HDR_DEST_HI   = 4'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_SENDER_LO = 4'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_SENDER_HI = 4'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_UID_B0    = 4'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_UID_B1    = 4'd5;
	localparam logic [HDR_IDX_W-1:0] HDR_UID_B2    = 4'd6;
	localparam logic [HDR_IDX_W-1:0] HDR_UID_B3    = 4'd7;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_BODY,
		PH_CLOSE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_OK,
		KIND_BAD_CLOSE,
		KIND_BAD_OPEN
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] dest;
		logic [15:0] sender;
		logic [31:0] uid;
		logic [7:0]  len;
	} res_t;

endpackage

// ----- hw/rtl/pfd_parser.sv -----
module pfd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output pfd_pkg::res_t res
);

	pfd_pkg::phase_t                  phase_q, phase_d;
	logic [pfd_pkg::HDR_IDX_W-1:0]    hdr_idx_q, hdr_idx_d;
	logic [15:0]                      dest_q, dest_d;
	logic [15:0]                      sender_q, sender_d;
	logic [31:0]                      uid_q, uid_d;
	logic [7:0]                       len_q, len_d;
	logic [7:0]                       count_q, count_d;
	logic [7:0]                       count_inc;

	assign count_inc = count_q + 8'd1;

	// Next state and header capture.
	always_comb begin
		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		dest_d    = dest_q;
		sender_d  = sender_q;
		uid_d     = uid_q;
		len_d     = len_q;
		count_d   = count_q;
		case (phase_q)
			pfd_pkg::PH_IDLE: begin
				if (rx_byte == pfd_pkg::FRAME_FLAG) begin
					phase_d   = pfd_pkg::PH_HEAD;
					hdr_idx_d = '0;
				end
			end
			pfd_pkg::PH_HEAD: begin
				hdr_idx_d = hdr_idx_q + 1'b1;
				case (hdr_idx_q)
					pfd_pkg::HDR_DEST_LO:   dest_d[7:0]    = rx_byte;
					pfd_pkg::HDR_DEST_HI:   dest_d[15:8]   = rx_byte;
					pfd_pkg::HDR_SENDER_LO: sender_d[7:0]  = rx_byte;
					pfd_pkg::HDR_SENDER_HI: sender_d[15:8] = rx_byte;
					pfd_pkg::HDR_UID_B0:    uid_d[7:0]     = rx_byte;
					pfd_pkg::HDR_UID_B1:    uid_d[15:8]    = rx_byte;
					pfd_pkg::HDR_UID_B2:    uid_d[23:16]   = rx_byte;
					pfd_pkg::HDR_UID_B3:    uid_d[31:24]   = rx_byte;
					default: begin
						// Length byte; an empty payload goes straight to the close flag.
						len_d     = rx_byte;
						count_d   = '0;
						hdr_idx_d = '0;
						phase_d   = (rx_byte == 8'd0) ? pfd_pkg::PH_CLOSE : pfd_pkg::PH_BODY;
					end
				endcase
			end
			pfd_pkg::PH_BODY: begin
				count_d = count_inc;
				if (count_inc == len_q)
					phase_d = pfd_pkg::PH_CLOSE;
			end
			default: begin
				phase_d   = pfd_pkg::PH_IDLE;
				hdr_idx_d = '0;
				count_d   = '0;
			end
		endcase
	end

	// Result for the byte in flight, taken from the state before the update.
	always_comb begin
		res        = '0;
		res.data   = rx_byte;
		res.dest   = dest_q;
		res.sender = sender_q;
		res.uid    = uid_q;
		res.len    = len_q;
		case (phase_q)
			pfd_pkg::PH_IDLE: begin
				res.valid  = (rx_byte != pfd_pkg::FRAME_FLAG);
				res.kind   = pfd_pkg::KIND_BAD_OPEN;
				res.dest   = '0;
				res.sender = '0;
				res.uid    = '0;
				res.len    = '0;
			end
			pfd_pkg::PH_HEAD: begin
				res.valid = 1'b0;
				res.kind  = pfd_pkg::KIND_DATA;
			end
			pfd_pkg::PH_BODY: begin
				res.valid = 1'b1;
				res.kind  = pfd_pkg::KIND_DATA;
			end
			default: begin
				res.valid = 1'b1;
				res.kind  = (rx_byte == pfd_pkg::FRAME_FLAG) ? pfd_pkg::KIND_OK
					: pfd_pkg::KIND_BAD_CLOSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pfd_pkg::PH_IDLE;
			hdr_idx_q <= '0;
			dest_q    <= '0;
			sender_q  <= '0;
			uid_q     <= '0;
			len_q     <= '0;
			count_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			dest_q    <= dest_d;
			sender_q  <= sender_d;
			uid_q     <= uid_d;
			len_q     <= len_d;
			count_q   <= count_d;
		end
	end

endmodule

// ----- hw/rtl/pfd_out_reg.sv -----
module pfd_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_accept,
	input  pfd_pkg::res_t                res,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pfd_pkg::TDATA_W-1:0]  out_data,
	output logic [pfd_pkg::TUSER_W-1:0]  out_user
);

	logic          valid_s1;
	pfd_pkg::res_t res_s1;

	// The register frees up in the same cycle its result is taken.
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_user  = res_s1.kind;
	assign out_data  = {res_s1.len, res_s1.uid, res_s1.sender, res_s1.dest, res_s1.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= res.valid;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res.valid) begin
			res_s1 <= res;
		end
	end

endmodule

// ----- hw/rtl/packet_frame_deframer.sv -----
// A byte that gives a result shows it on the master side in the cycle after it is taken.
// Throughput: one byte per cycle; a byte is taken whenever the result register is empty
// or being drained in the same cycle.
// Header bytes and a good open flag give no result.
// Reset (arst_n low) returns the parser to idle and clears the captured header and the
// result register's valid flag.
module packet_frame_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [7:0] payload_byte, [23:8] destination, [39:24] sender, [71:40] frame_uid,
	// [79:72] payload_len
	output logic [pfd_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic [pfd_pkg::TUSER_W-1:0]  m_axis_tuser   // [1:0] kind
);

	logic          accept;
	pfd_pkg::res_t res;

	assign accept = s_axis_tvalid && s_axis_tready;

	pfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_axis_tdata),
		.res     (res)
	);

	pfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (accept),
		.res       (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// ----- hw/rtl/pfd_checker.sv -----
module pfd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [7:0]                   s_axis_tdata,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [pfd_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic [pfd_pkg::TUSER_W-1:0]  m_axis_tuser
);

	// A stalled result holds its value until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// A full result register that is not drained must block new requests.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while result stalled");

	// A bad open flag carries no header.
	a_bad_open_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pfd_pkg::KIND_BAD_OPEN |->
			m_axis_tdata[79:8] == '0)
		else $error("bad open result carries header bits");

	// Payload bytes only come from frames with a nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pfd_pkg::KIND_DATA |-> m_axis_tdata[79:72] != 8'd0)
		else $error("payload byte from an empty frame");

	// With an empty result register the block takes the next request.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("block not ready while output is empty");

endmodule

bind packet_frame_deframer pfd_checker u_pfd_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int RUN_BYTES   = 1500;
	localparam int CALM_BYTES  = 300;
	localparam int HOLD_AT     = 800;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	// Tracks the parser state on its own and holds the results each byte should cause.
	class deframer_scoreboard;
		pfd_pkg::phase_t                        ph;
		logic [pfd_pkg::HDR_IDX_W-1:0]          hdr_pos;
		logic [15:0]                            dest;
		logic [15:0]                            sender;
		logic [31:0]                            uid;
		logic [7:0]                             len;
		logic [7:0]                             count;
		pfd_pkg::res_t                          due[$];
		int                                     mismatches;

		function new();
			ph         = pfd_pkg::PH_IDLE;
			hdr_pos    = '0;
			dest       = '0;
			sender     = '0;
			uid        = '0;
			len        = '0;
			count      = '0;
			mismatches = 0;
		endfunction

		function void take_byte(logic [7:0] b);
			pfd_pkg::res_t r;
			r       = '0;
			r.valid = 1'b1;
			r.data  = b;
			case (ph)
				pfd_pkg::PH_IDLE: begin
					if (b == pfd_pkg::FRAME_FLAG) begin
						ph      = pfd_pkg::PH_HEAD;
						hdr_pos = '0;
					end else begin
						r.kind = pfd_pkg::KIND_BAD_OPEN;
						due.push_back(r);
					end
				end
				pfd_pkg::PH_HEAD: begin
					if (hdr_pos > pfd_pkg::HDR_UID_B3) begin
						// Length byte ends the header; a zero length goes straight to the close.
						len     = b;
						count   = '0;
						hdr_pos = '0;
						ph      = (b == 8'd0) ? pfd_pkg::PH_CLOSE : pfd_pkg::PH_BODY;
					end else begin
						case (hdr_pos)
							pfd_pkg::HDR_DEST_LO:   dest[7:0]    = b;
							pfd_pkg::HDR_DEST_HI:   dest[15:8]   = b;
							pfd_pkg::HDR_SENDER_LO: sender[7:0]  = b;
							pfd_pkg::HDR_SENDER_HI: sender[15:8] = b;
							pfd_pkg::HDR_UID_B0:    uid[7:0]     = b;
							pfd_pkg::HDR_UID_B1:    uid[15:8]    = b;
							pfd_pkg::HDR_UID_B2:    uid[23:16]   = b;
							default:                uid[31:24]   = b;
						endcase
						hdr_pos = hdr_pos + 1'b1;
					end
				end
				pfd_pkg::PH_BODY: begin
					count = count + 1'b1;
					if (count == len)
						ph = pfd_pkg::PH_CLOSE;
					r.kind   = pfd_pkg::KIND_DATA;
					r.dest   = dest;
					r.sender = sender;
					r.uid    = uid;
					r.len    = len;
					due.push_back(r);
				end
				default: begin
					r.kind   = (b == pfd_pkg::FRAME_FLAG) ? pfd_pkg::KIND_OK
						: pfd_pkg::KIND_BAD_CLOSE;
					r.dest   = dest;
					r.sender = sender;
					r.uid    = uid;
					r.len    = len;
					due.push_back(r);
					ph      = pfd_pkg::PH_IDLE;
					hdr_pos = '0;
					count   = '0;
				end
			endcase
		endfunction

		function void check_output(logic [pfd_pkg::TUSER_W-1:0] kind,
				logic [pfd_pkg::TDATA_W-1:0] data);
			pfd_pkg::res_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing expected: kind %0d data %h",
						$realtime, kind, data);
				return;
			end
			want = due.pop_front();
			if (kind !== want.kind || data[7:0] !== want.data || data[23:8] !== want.dest ||
					data[39:24] !== want.sender || data[71:40] !== want.uid ||
					data[79:72] !== want.len) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: expected kind %0d byte %h dest %h sender %h uid %h len %h",
						$realtime, want.kind, want.data, want.dest, want.sender, want.uid,
						want.len);
					$display("%0t:      got kind %0d byte %h dest %h sender %h uid %h len %h",
						$realtime, kind, data[7:0], data[23:8], data[39:24], data[71:40],
						data[79:72]);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [pfd_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic [pfd_pkg::TUSER_W-1:0]   m_axis_tuser;

	deframer_scoreboard   sb = new();
	int                   bytes_sent = 0;
	bit                   gaps_on = 1'b0;
	bit                   hold_req = 1'b0;
	int                   hold_count = 0;
	int                   cycles = 0;

	packet_frame_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: check every accepted result, then choose next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tuser, m_axis_tdata);
		if (hold_req && hold_count < HOLD_CYCLES) begin
			hold_count    <= hold_count + 1;
			m_axis_tready <= 1'b0;
		end else if (!gaps_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 32);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(0, 99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [15:0] dest, input logic [15:0] sender,
			input logic [31:0] uid, input logic [7:0] len);
		send_byte(pfd_pkg::FRAME_FLAG);
		send_byte(dest[7:0]);
		send_byte(dest[15:8]);
		send_byte(sender[7:0]);
		send_byte(sender[15:8]);
		send_byte(uid[7:0]);
		send_byte(uid[15:8]);
		send_byte(uid[23:16]);
		send_byte(uid[31:24]);
		send_byte(len);
	endtask

	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	task automatic send_random_frame();
		logic [7:0] len;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 85)
			len = 8'($urandom_range(0, 8));
		else if (r < 98)
			len = 8'($urandom_range(9, 40));
		else
			len = 8'($urandom_range(200, 255));
		send_header(pick_addr(), pick_addr(), $urandom(), len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom()));
		if ($urandom_range(0, 99) < 85)
			send_byte(pfd_pkg::FRAME_FLAG);
		else
			send_byte(8'($urandom()));
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray bytes while idle, then header extremes with an empty payload,
		// then a payload that holds the flag value and a broken close.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd0);
		send_byte(pfd_pkg::FRAME_FLAG);
		send_header(16'h0000, 16'h0000, 32'h0000_0000, 8'd1);
		send_byte(pfd_pkg::FRAME_FLAG);
		send_byte(8'h00);

		gaps_on = 1'b1;
		while (bytes_sent < RUN_BYTES) begin
			gaps_on = !(bytes_sent > 100 && bytes_sent < 100 + CALM_BYTES);
			if (!hold_req && bytes_sent > HOLD_AT)
				hold_req = 1'b1;
			if ($urandom_range(0, 99) < 12) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom()));
			end else begin
				send_random_frame();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
